@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`endif

@@ sv/sadmc_pkg.sv @@
// ---------------------------------------------------------------------------
// sadmc_pkg
// types, constants and helper functions of the multi-candidate SAD engine
// ---------------------------------------------------------------------------
`default_nettype none

package sadmc_pkg;

    // pixel and row geometry
    localparam int PIX_W       = 8;
    localparam int SRC_PIXELS  = 16;
    localparam int REF_PIXELS  = 23;
    localparam int SUM_W       = 16;
    localparam int GRP_W       = 10;
    localparam int SIZE_W      = 5;
    localparam int CODE_W      = 2;
    localparam int CAND_W      = 3;
    localparam int MODE_CNT_W  = 4;

    // parameter defaults
    localparam int DEF_MAX_WIDTH      = 16;
    localparam int DEF_MAX_CANDIDATES = 8;

    // stream payload widths
    localparam int S_TDATA_W = 312;
    localparam int M_TDATA_W = 24;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_CAND   = 2'd2
    } cfg_reg_e;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [SUM_W-1:0] sum_t;

    // per-lane pipeline control
    typedef struct packed {
        logic load;    // take a new row into the difference stage
        logic accum;   // add the staged row into the accumulator
        logic clear;   // block ends with this row: zero the accumulator
    } lane_ctrl_t;

    // size code to pixel or row count, code three acts as 16
    function automatic logic [SIZE_W-1:0] code_to_size(input logic [CODE_W-1:0] code);
        logic [SIZE_W-1:0] sz;
        case (code)
            2'd0:    sz = 5'd4;
            2'd1:    sz = 5'd8;
            default: sz = 5'd16;
        endcase
        return sz;
    endfunction

    // candidate mode to offset count, code three acts as eight
    function automatic logic [MODE_CNT_W-1:0] mode_to_count(input logic [CODE_W-1:0] mode);
        logic [MODE_CNT_W-1:0] n;
        case (mode)
            2'd0:    n = 4'd1;
            2'd1:    n = 4'd3;
            default: n = 4'd8;
        endcase
        return n;
    endfunction

    function automatic pixel_t abs_diff(input pixel_t a, input pixel_t b);
        return (a > b) ? pixel_t'(a - b) : pixel_t'(b - a);
    endfunction

endpackage

`default_nettype wire

@@ sv/block_sad_multi_candidate.sv @@
// ---------------------------------------------------------------------------
// block_sad_multi_candidate
// multi-candidate SAD engine for motion estimation, one block row per item
// ---------------------------------------------------------------------------
// Takes one block row per clock unless the result buffer holds it back. Each
// candidate offset has its own lane that forms the row's absolute differences,
// sums them in groups of four, registers those group sums and adds the row into
// the block sum. On the row that reaches or passes the block height, the block
// sums are copied to a result buffer once that row has passed the group-sum
// register, and the SADs leave from that buffer. One SAD per active candidate
// leaves per cycle while m_tready is high, candidate 0 first, tlast on the
// final one. The input keeps full rate as long as the result buffer is read out
// before the next block ends; for a block of H rows with N active candidates,
// the input pauses only when N exceeds H or the output stalls.
// Configuration writes are accepted at any time and should be made while idle.
`default_nettype none

module block_sad_multi_candidate #(
    parameter int MAX_WIDTH      = sadmc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CANDIDATES = sadmc_pkg::DEF_MAX_CANDIDATES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // row items: src_low, src_high, ref_first, ref_middle, ref_tail
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sadmc_pkg::S_TDATA_W-1:0]  s_tdata,
    // result items: candidate, sad_value, zero pad; tlast is last_of_block
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [sadmc_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tlast,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [sadmc_pkg::CODE_W-1:0]     cfg_data
);
    import sadmc_pkg::*;

    localparam int NCW       = $clog2(MAX_CANDIDATES + 1);
    localparam int SRC_BASE  = 0;
    localparam int REF_BASE  = SRC_PIXELS * PIX_W;

    logic [CODE_W-1:0] width_code_reg;
    logic [CODE_W-1:0] height_code_reg;
    logic [CODE_W-1:0] cand_mode_reg;

    logic [3:0]        row_cnt_reg;
    logic [3:0]        row_cnt_next;
    logic              v1_reg;
    logic              end1_reg;
    logic [NCW-1:0]    ncand1_reg;

    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height;
    logic [SIZE_W-1:0] rows;
    logic              row_end;
    logic [NCW-1:0]    ncand;
    logic [MODE_CNT_W-1:0] mode_cnt;

    logic              adv;
    logic              accept;
    logic              snap_free;
    logic              snap_load;
    lane_ctrl_t        lane_ctrl;

    pixel_t            src_pix [SRC_PIXELS];
    pixel_t            ref_pix [REF_PIXELS];
    sum_t              totals  [MAX_CANDIDATES];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_code_reg  <= 2'd2;
            height_code_reg <= 2'd2;
            cand_mode_reg   <= 2'd0;
        end else if (cfg_valid) begin
            case (cfg_reg_e'(cfg_index))
                REG_WIDTH:  width_code_reg  <= cfg_data;
                REG_HEIGHT: height_code_reg <= cfg_data;
                REG_CAND:   cand_mode_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // row payload unpacking
    always_comb begin
        for (int i = 0; i < SRC_PIXELS; i++) begin
            src_pix[i] = s_tdata[SRC_BASE + PIX_W * i +: PIX_W];
        end
        for (int i = 0; i < REF_PIXELS; i++) begin
            ref_pix[i] = s_tdata[REF_BASE + PIX_W * i +: PIX_W];
        end
    end

    // block geometry at the input
    always_comb begin
        width_eff = code_to_size(width_code_reg);
        if (width_eff > SIZE_W'(MAX_WIDTH)) begin
            width_eff = SIZE_W'(MAX_WIDTH);
        end
        height   = code_to_size(height_code_reg);
        rows     = SIZE_W'(row_cnt_reg) + SIZE_W'(1);
        row_end  = rows >= height;
        mode_cnt = mode_to_count(cand_mode_reg);
        if (mode_cnt > MODE_CNT_W'(MAX_CANDIDATES)) begin
            ncand = NCW'(MAX_CANDIDATES);
        end else begin
            ncand = NCW'(mode_cnt);
        end
        row_cnt_next = row_end ? 4'd0 : rows[3:0];
    end

    // pipeline advance: hold when a block ends and the buffer is still busy
    assign adv       = !(v1_reg && end1_reg && !snap_free);
    assign s_tready  = adv;
    assign accept    = s_tvalid && adv;
    assign snap_load = v1_reg && adv && end1_reg;

    assign lane_ctrl.load  = accept;
    assign lane_ctrl.accum = v1_reg && adv;
    assign lane_ctrl.clear = end1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            v1_reg      <= 1'b0;
            end1_reg    <= 1'b0;
            ncand1_reg  <= '0;
        end else begin
            if (accept) begin
                row_cnt_reg <= row_cnt_next;
                end1_reg    <= row_end;
                ncand1_reg  <= ncand;
            end
            if (adv) begin
                v1_reg <= accept;
            end
        end
    end

    // one lane per candidate offset
    for (genvar k = 0; k < MAX_CANDIDATES; k++) begin : g_lane
        sadmc_lane #(
            .LANE      (k),
            .MAX_WIDTH (MAX_WIDTH)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .width   (width_eff),
            .src_pix (src_pix),
            .ref_pix (ref_pix),
            .total   (totals[k])
        );
    end

    // result buffer and read-out
    sadmc_merge #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .NCW            (NCW)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (snap_load),
        .ncand    (ncand1_reg),
        .totals   (totals),
        .free     (snap_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ sv/sadmc_lane.sv @@
// ---------------------------------------------------------------------------
// sadmc_lane
// one candidate offset: row absolute differences, partial sums, accumulator
// ---------------------------------------------------------------------------
`default_nettype none

module sadmc_lane #(
    parameter int LANE      = 0,
    parameter int MAX_WIDTH = sadmc_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire sadmc_pkg::lane_ctrl_t              ctrl,
    input  wire logic [sadmc_pkg::SIZE_W-1:0]       width,
    input  wire sadmc_pkg::pixel_t                  src_pix [sadmc_pkg::SRC_PIXELS],
    input  wire sadmc_pkg::pixel_t                  ref_pix [sadmc_pkg::REF_PIXELS],
    output sadmc_pkg::sum_t                         total
);
    import sadmc_pkg::*;

    localparam int NGRP = (MAX_WIDTH + 3) / 4;

    logic [GRP_W-1:0] grp_reg  [NGRP];
    logic [GRP_W-1:0] grp_next [NGRP];
    sum_t             acc_reg;
    sum_t             row_sum;

    // absolute differences in groups of four columns, masked by the width
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if ((4 * g + j < MAX_WIDTH) && (SIZE_W'(4 * g + j) < width)) begin
                    grp_next[g] = grp_next[g]
                                + GRP_W'(abs_diff(src_pix[4 * g + j],
                                                  ref_pix[4 * g + j + LANE]));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            grp_reg <= grp_next;
        end
    end

    // row sum and running block sum
    always_comb begin
        row_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            row_sum = row_sum + SUM_W'(grp_reg[g]);
        end
        total = acc_reg + row_sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctrl.accum) begin
            acc_reg <= ctrl.clear ? '0 : total;
        end
    end

endmodule

`default_nettype wire

@@ sv/sadmc_merge.sv @@
// ---------------------------------------------------------------------------
// sadmc_merge
// captures the finished lane sums of a block and sends them out in order
// ---------------------------------------------------------------------------
`default_nettype none

module sadmc_merge #(
    parameter int MAX_CANDIDATES = sadmc_pkg::DEF_MAX_CANDIDATES,
    parameter int NCW            = $clog2(MAX_CANDIDATES + 1)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            load,
    input  wire logic [NCW-1:0]                  ncand,
    input  wire sadmc_pkg::sum_t                 totals [MAX_CANDIDATES],
    output logic                                 free,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [sadmc_pkg::M_TDATA_W-1:0]      m_tdata,   // candidate, sad_value, zero pad
    output logic                                 m_tlast
);
    import sadmc_pkg::*;

    localparam int IDXW  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int PAD_W = M_TDATA_W - CAND_W - SUM_W;

    sum_t            sums_reg [MAX_CANDIDATES];
    logic [NCW-1:0]  ncand_reg;
    logic [IDXW-1:0] idx_reg;
    logic            valid_reg;
    logic            is_last;
    logic            take;

    assign is_last  = (NCW'(idx_reg) + NCW'(1)) == ncand_reg;
    assign take     = valid_reg && m_tready;
    assign free     = !valid_reg || (take && is_last);

    // output item
    assign m_tvalid = valid_reg;
    assign m_tlast  = is_last;
    assign m_tdata  = {PAD_W'(0), sums_reg[idx_reg], CAND_W'(idx_reg)};

    // result buffer payload
    always_ff @(posedge aclk) begin
        if (load) begin
            sums_reg  <= totals;
            ncand_reg <= ncand;
        end
    end

    // read-out control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (take) begin
            if (is_last) begin
                valid_reg <= 1'b0;
                idx_reg   <= '0;
            end else begin
                idx_reg <= idx_reg + IDXW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/sadmc_checker.sv @@
// ---------------------------------------------------------------------------
// sadmc_checker
// port-level checks of the SAD engine, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sadmc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [sadmc_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                            m_tlast
);

    // a stalled result item holds its payload
    `ASSERT_PROP(a_hold_result, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))

    // a block sum never exceeds 16 rows of 16 pixels at full swing
    `ASSERT_NEVER(a_sad_range, aclk, aresetn, m_tvalid && (m_tdata[18:3] > 16'd65280))

    // within a block the next candidate follows at once
    `ASSERT_PROP(a_cand_step, aclk, aresetn, (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && (m_tdata[2:0] == 3'($past(m_tdata[2:0]) + 3'd1))))

    // a new block starts at candidate zero
    `ASSERT_PROP(a_cand_restart, aclk, aresetn, (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || (m_tdata[2:0] == 3'd0)))

    // with no result item waiting an offered row is always taken
    `ASSERT_PROP(a_no_idle_stall, aclk, aresetn, (!m_tvalid && s_tvalid) |-> s_tready)

endmodule

bind block_sad_multi_candidate sadmc_checker u_sadmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the multi-candidate SAD engine
// ---------------------------------------------------------------------------
// Block rows are streamed into the engine while a scoreboard keeps its own
// copy of the eight candidate accumulators, the row counter and the size
// registers. Every accepted row updates that copy. When a block completes,
// one expected SAD per active candidate is queued. Each result item leaving
// the engine is checked in order against that queue. A short directed run
// covers the largest possible SAD, the saturating size codes and size
// changes in the middle of a block. Random phases with new register settings
// follow. Both stream sides stall at random.
`default_nettype none

module tb_top;

    import sadmc_pkg::*;

    // row stimulus kinds
    localparam int ROW_RANDOM    = 0;
    localparam int ROW_SATURATED = 1;
    localparam int ROW_CLOSE     = 2;

    localparam int ROW_W       = S_TDATA_W;
    localparam int RANDOM_ROWS = 390;

    typedef struct {
        logic [CAND_W-1:0] cand;
        logic [SUM_W-1:0]  sad;
        logic              last;
    } sad_result_t;

    // reference accumulators and queue of SADs still to come
    class sad_scoreboard;
        logic [SUM_W-1:0] cand_sums[8];
        logic [3:0]       row_cnt;
        logic [1:0]       width_code;
        logic [1:0]       height_code;
        logic [1:0]       cand_mode;
        sad_result_t      expected_sads[$];
        int               errors;

        function new();
            foreach (cand_sums[k]) cand_sums[k] = '0;
            row_cnt     = '0;
            width_code  = 2'd2;
            height_code = 2'd2;
            cand_mode   = 2'd0;
            errors      = 0;
        endfunction

        function void set_reg(cfg_reg_e idx, logic [1:0] v);
            case (idx)
                REG_WIDTH:  width_code  = v;
                REG_HEIGHT: height_code = v;
                REG_CAND:   cand_mode   = v;
                default: ;
            endcase
        endfunction

        // accumulate one row, queue the block's SADs when it completes
        function void note_row(logic [ROW_W-1:0] d);
            logic [7:0]  src_px[16];
            logic [7:0]  ref_px[24];
            logic [7:0]  diff;
            int          width;
            int          height;
            int          count;
            int          rows;
            sad_result_t res;
            for (int c = 0; c < 16; c++) src_px[c] = d[8*c +: 8];
            for (int j = 0; j < 23; j++) ref_px[j] = d[128 + 8*j +: 8];
            ref_px[23] = '0;
            width  = (width_code == 2'd0) ? 4 : (width_code == 2'd1) ? 8 : 16;
            height = (height_code == 2'd0) ? 4 : (height_code == 2'd1) ? 8 : 16;
            // every accumulator runs regardless of the candidate mode
            for (int k = 0; k < 8; k++) begin
                for (int c = 0; c < width; c++) begin
                    diff = (src_px[c] > ref_px[c+k]) ? src_px[c] - ref_px[c+k]
                                                     : ref_px[c+k] - src_px[c];
                    cand_sums[k] = cand_sums[k] + SUM_W'(diff);
                end
            end
            rows = int'(row_cnt) + 1;
            if (rows < height) begin
                row_cnt = 4'(rows);
                return;
            end
            case (cand_mode)
                2'd0:    count = 1;
                2'd1:    count = 3;
                default: count = 8;
            endcase
            for (int k = 0; k < count; k++) begin
                res.cand = CAND_W'(k);
                res.sad  = cand_sums[k];
                res.last = (k == count - 1);
                expected_sads.push_back(res);
            end
            foreach (cand_sums[k]) cand_sums[k] = '0;
            row_cnt = '0;
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tlast);
            sad_result_t exp_res;
            if (expected_sads.size() == 0) begin
                $error("result item with none expected: candidate %0d sad %0d",
                       tdata[2:0], tdata[18:3]);
                errors++;
                return;
            end
            exp_res = expected_sads.pop_front();
            if (tdata[2:0] !== exp_res.cand) begin
                $error("candidate: expected %0d actual %0d", exp_res.cand, tdata[2:0]);
                errors++;
            end
            if (tdata[18:3] !== exp_res.sad) begin
                $error("sad_value: expected %0d actual %0d", exp_res.sad, tdata[18:3]);
                errors++;
            end
            if (tlast !== exp_res.last) begin
                $error("last_of_block: expected %0b actual %0b", exp_res.last, tlast);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [ROW_W-1:0]     s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [CODE_W-1:0]    cfg_data  = '0;

    logic                 calm      = 1'b0;
    int                   sent      = 0;
    sad_scoreboard        sb        = new();

    always #1 aclk = ~aclk;

    block_sad_multi_candidate i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 22);
    end

    // check every accepted result item
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast);
        end
    end

    function automatic logic [ROW_W-1:0] make_row(int kind);
        logic [ROW_W-1:0] d;
        logic [7:0]       base;
        base = 8'($urandom);
        for (int i = 0; i < ROW_W / 8; i++) begin
            case (kind)
                ROW_SATURATED: d[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                ROW_CLOSE:     d[8*i +: 8] = base + 8'($urandom_range(0, 3));
                default:       d[8*i +: 8] = 8'($urandom);
            endcase
        end
        return d;
    endfunction

    // drive one row item, idle cycles in front of it at random
    task automatic send_row(logic [ROW_W-1:0] d);
        while (!calm && $urandom_range(0, 99) < 22) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_row(d);
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_e idx, logic [1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // hold the input until all SADs are out and the pipeline has settled
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.expected_sads.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // main stimulus
    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // largest possible SAD at reset sizes: 16 rows of full contrast
        repeat (16) send_row({184'h0, {128{1'b1}}});
        drain_results();

        // block started at 4 wide, 8 high, three candidates
        write_reg(REG_WIDTH, 2'd0);
        write_reg(REG_HEIGHT, 2'd1);
        write_reg(REG_CAND, 2'd1);
        send_row({{184{1'b1}}, 128'h0});
        send_row({8'h00, {11{16'hFF00}}, {8{16'h00FF}}});
        send_row({ROW_W{1'b1}});
        send_row(make_row(ROW_RANDOM));
        send_row(make_row(ROW_CLOSE));
        drain_results();

        // height lowered below rows taken, width and mode set to code three
        write_reg(REG_WIDTH, 2'd3);
        write_reg(REG_HEIGHT, 2'd0);
        write_reg(REG_CAND, 2'd3);
        send_row({184'h0, {128{1'b1}}});
        drain_results();

        // random phases, new settings between them
        while (sent < RANDOM_ROWS) begin
            drain_results();
            repeat ($urandom_range(1, 3)) begin
                write_reg(cfg_reg_e'($urandom_range(0, 2)), 2'($urandom_range(0, 3)));
            end
            calm <= (sent >= 150 && sent < 260);
            repeat ($urandom_range(1, 24)) begin
                case ($urandom_range(0, 3))
                    1:       send_row(make_row(ROW_SATURATED));
                    2:       send_row(make_row(ROW_CLOSE));
                    default: send_row(make_row(ROW_RANDOM));
                endcase
                sent++;
            end
        end

        drain_results();
        repeat (20) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
